// File: rtl/assert_macros.svh
// assertion macros shared by the stack rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define MTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define MTS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: rtl/mts_pkg.sv
// shared types, codes and constants of the min tracking stack
package mts_pkg;

  localparam int unsigned DEFAULT_STACK_DEPTH = 256;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned COUNT_OUT_W = 9;
  localparam int unsigned STATUS_W = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic push;
    logic drop;
    logic under;
    logic pop_last;
    logic pop_rd;
    logic pop_ld;
    logic load;
  } mts_cmd_t;

  typedef struct packed {
    logic empty;
    logic single;
    logic full;
  } mts_sts_t;

endpackage

// File: rtl/mts_ram.sv
// generic single write port ram with registered read
module mts_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mts_ctrl.sv
// controller: request handshake, op decode and pop read sequencing
`include "assert_macros.svh"
module mts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  mts_pkg::mts_sts_t  sts_i,
  output mts_pkg::mts_cmd_t  cmd_o
);
  import mts_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WAIT = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic acc;
  mts_cmd_t cmd;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    cmd = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (op_i == OP_PUSH) begin
            cmd.push = !sts_i.full;
            cmd.drop = sts_i.full;
          end else if (sts_i.empty) begin
            cmd.under = 1'b1;
          end else if (sts_i.single) begin
            cmd.pop_last = 1'b1;
          end else begin
            cmd.pop_rd = 1'b1;
            state_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        cmd.pop_ld = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    cmd.load = cmd.push || cmd.drop || cmd.under || cmd.pop_last || cmd.pop_ld;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o = cmd;

  `MTS_ASSERT(a_rd_then_ld, clk_i, rst_ni, cmd.pop_rd |=> cmd.pop_ld)
  `MTS_ASSERT(a_no_push_full, clk_i, rst_ni, cmd.push |-> !sts_i.full)
  `MTS_ASSERT(a_ld_slot_free, clk_i, rst_ni, cmd.pop_ld |-> !out_valid_q)

endmodule

// File: rtl/mts_dp.sv
// datapath: top registers, level store, fill count and result registers
`include "assert_macros.svh"
module mts_dp #(
  parameter int unsigned STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mts_pkg::mts_cmd_t                     cmd_i,
  output mts_pkg::mts_sts_t                     sts_o,
  input  logic signed [mts_pkg::DATA_W-1:0]     push_value_i,
  output logic signed [mts_pkg::DATA_W-1:0]     top_value_o,
  output logic signed [mts_pkg::DATA_W-1:0]     min_value_o,
  output logic                                  is_empty_o,
  output logic [mts_pkg::STATUS_W-1:0]          status_o,
  output logic [mts_pkg::COUNT_OUT_W-1:0]       entry_count_o
);
  import mts_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [CW-1:0] count_q, count_d, count_m1, count_m2;
  logic signed [DATA_W-1:0] top_q, top_d, min_q, min_d;
  logic [2*DATA_W-1:0] rdata;
  logic empty;

  logic signed [DATA_W-1:0] out_top_q, out_min_q;
  logic out_empty_q;
  logic [STATUS_W-1:0] out_status_q, status_d;
  logic [COUNT_OUT_W-1:0] out_count_q;

  assign count_m1 = count_q - CW'(1);
  assign count_m2 = count_q - CW'(2);
  assign empty = (count_q == '0);

  assign sts_o.empty = empty;
  assign sts_o.single = (count_q == CW'(1));
  assign sts_o.full = (count_q == CW'(STACK_DEPTH));

  // entries below the top; the top level lives in top_q and min_q
  mts_ram #(
    .WIDTH(2 * DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push && !empty),
    .waddr_i (count_m1[AW-1:0]),
    .wdata_i ({top_q, min_q}),
    .raddr_i (count_m2[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    top_d = top_q;
    min_d = min_q;
    count_d = count_q;
    if (cmd_i.push) begin
      top_d = push_value_i;
      min_d = (!empty && (min_q < push_value_i)) ? min_q : push_value_i;
      count_d = count_q + CW'(1);
    end
    if (cmd_i.pop_last || cmd_i.pop_rd) begin
      count_d = count_m1;
    end
    if (cmd_i.pop_ld) begin
      top_d = $signed(rdata[2*DATA_W-1:DATA_W]);
      min_d = $signed(rdata[DATA_W-1:0]);
    end
  end

  always_comb begin
    status_d = STATUS_OK;
    if (cmd_i.drop) begin
      status_d = STATUS_OVERFLOW;
    end else if (cmd_i.under) begin
      status_d = STATUS_UNDERFLOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    min_q <= min_d;
    if (cmd_i.load) begin
      out_top_q <= (count_d == '0) ? '0 : top_d;
      out_min_q <= (count_d == '0) ? '0 : min_d;
      out_empty_q <= (count_d == '0);
      out_status_q <= status_d;
      out_count_q <= COUNT_OUT_W'(count_d);
    end
  end

  assign top_value_o = out_top_q;
  assign min_value_o = out_min_q;
  assign is_empty_o = out_empty_q;
  assign status_o = out_status_q;
  assign entry_count_o = out_count_q;

  `MTS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(STACK_DEPTH))
  `MTS_ASSERT(a_ld_after_rd, clk_i, rst_ni, cmd_i.pop_ld |-> count_q != '0)

endmodule

// File: rtl/min_tracking_stack.sv
// top level of the min tracking stack
// Stack of signed 32-bit values that also reports the least value held. Every request (push or
// pop) gives one result with top, minimum, empty flag, status and entry count after the
// operation; top and minimum read 0 when empty, a pop on empty is flagged as underflow and a push
// on full as overflow. A push, underflow, overflow or emptying pop gives its result in the
// cycle after it is taken; a pop that leaves entries first does a registered read of the level
// store to refill the top registers. A new request is taken while the previous result is being
// taken. The store needs no clearing pass after reset; unwritten levels are never read.
module min_tracking_stack #(
  parameter int unsigned STACK_DEPTH = mts_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  op_i,
  input  logic signed [mts_pkg::DATA_W-1:0]     push_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mts_pkg::DATA_W-1:0]     top_value_o,
  output logic signed [mts_pkg::DATA_W-1:0]     min_value_o,
  output logic                                  is_empty_o,
  output logic [mts_pkg::STATUS_W-1:0]          status_o,
  output logic [mts_pkg::COUNT_OUT_W-1:0]       entry_count_o
);
  import mts_pkg::*;

  mts_cmd_t cmd;
  mts_sts_t sts;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mts_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .push_value_i  (push_value_i),
    .top_value_o   (top_value_o),
    .min_value_o   (min_value_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

endmodule
